### hdl/ate_pkg.sv
package ate_pkg;

   localparam int DEF_STACK_DEPTH  = 16;
   localparam int DEF_CORDIC_STEPS = 24;

   localparam logic signed [31:0] Q_ONE = 32'sd65536;
   localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [35:0] Q30_GAIN    = 36'sd652032874;

   typedef enum logic [3:0] {
      CMD_IDENTITY = 4'd0,
      CMD_ZERO     = 4'd1,
      CMD_WRITE    = 4'd2,
      CMD_SCALE    = 4'd3,
      CMD_TRANS    = 4'd4,
      CMD_ROTATE   = 4'd5,
      CMD_SCALAR   = 4'd6,
      CMD_POINT    = 4'd7,
      CMD_PUSH     = 4'd8,
      CMD_POP      = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REDUCE,
      S_FOLD,
      S_CORDIC,
      S_CROUND,
      S_MAC,
      S_MACW,
      S_PUSH,
      S_POPRD,
      S_POPWT,
      S_POPLD,
      S_DONE
   } state_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'd843314857;
         5'd1:  r = 32'd497837829;
         5'd2:  r = 32'd263043837;
         5'd3:  r = 32'd133525159;
         5'd4:  r = 32'd67021687;
         5'd5:  r = 32'd33543516;
         5'd6:  r = 32'd16775851;
         5'd7:  r = 32'd8388437;
         5'd8:  r = 32'd4194283;
         5'd9:  r = 32'd2097149;
         5'd31: r = 32'd1;
         default: r = 32'd1 << (5'd30 - i);
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

### hdl/affine_transform_engine_with_stack.sv
// One request at a time; busy is high from acceptance until the response
// strobe. The MAC unit performs one 32x32 multiply per S_MAC/S_MACW pair.
// rsp_valid pulses for one cycle; the receiver cannot stall. Synchronous
// reset loads identity and empties the stack.
module affine_transform_engine_with_stack
   import ate_pkg::*;
#(
   parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_type,
   input  logic               req_pop_request,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic signed [31:0] req_operand_c,
   input  logic [1:0]         req_element_row,
   input  logic [1:0]         req_element_col,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_w,
   output logic [1:0]         rsp_status
);
   localparam int AW = (STACK_DEPTH * 9 > 1) ? $clog2(STACK_DEPTH * 9) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int RAM_DEPTH = STACK_DEPTH * 9;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [1:0] row_ff, row_in, col_ff, col_in;
   logic signed [31:0] m_ff [9];
   logic signed [31:0] m_in [9];
   logic signed [31:0] t_ff [9];
   logic signed [31:0] t_in [9];
   logic signed [31:0] tmp_ff [9];
   logic signed [31:0] tmp_in [9];
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [4:0] step_ff, step_in;
   logic [3:0] idx_ff, idx_in;
   logic [1:0] k_ff, k_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [35:0] x_ff, x_in, y_ff, y_in;
   logic signed [47:0] z_ff, z_in;
   logic neg_ff, neg_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, pw_ff, pw_in;
   logic [1:0] st_ff, st_in;
   logic done_ff, done_in;

   logic ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [31:0] ram_wd, ram_rd;

   ate_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   // shared multiplier operands
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] rnd;
   logic [3:0] ii, jj;
   logic [AW-1:0] base;
   logic signed [47:0] zr;
   logic signed [35:0] xs, ys;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
         for (int i = 0; i < 9; i++)
            m_ff[i] <= (i == 0 || i == 4 || i == 8) ? Q_ONE : 32'sd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
         m_ff     <= m_in;
      end
      cmd_ff <= cmd_in; a_ff <= a_in; b_ff <= b_in; c_ff <= c_in;
      row_ff <= row_in; col_ff <= col_in; t_ff <= t_in; tmp_ff <= tmp_in;
      step_ff <= step_in; idx_ff <= idx_in; k_ff <= k_in;
      acc_ff <= acc_in; prod_ff <= prod_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; neg_ff <= neg_in;
      px_ff <= px_in; py_ff <= py_in; pw_ff <= pw_in; st_ff <= st_in;
   end

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; row_in = row_ff; col_in = col_ff;
      m_in = m_ff; t_in = t_ff; tmp_in = tmp_ff;
      cnt_in = cnt_ff; step_in = step_ff; idx_in = idx_ff; k_in = k_ff;
      acc_in = acc_ff; prod_in = prod_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; neg_in = neg_ff;
      px_in = px_ff; py_in = py_ff; pw_in = pw_ff; st_in = st_ff;
      done_in = 1'b0;
      ram_we = 1'b0; ram_wa = '0; ram_wd = '0; ram_ra = '0;
      base = AW'(cnt_ff * 9);
      case (idx_ff)
         4'd0, 4'd1, 4'd2: ii = 4'd0;
         4'd3, 4'd4, 4'd5: ii = 4'd1;
         default: ii = 4'd2;
      endcase
      jj = idx_ff - ii * 4'd3;
      mul_a = '0; mul_b = '0;
      rnd = (prod_ff + 64'sd32768) >>> 16;
      zr = '0; xs = '0; ys = '0;

      case (cmd_ff)
         CMD_SCALAR: begin mul_a = m_ff[idx_ff]; mul_b = a_ff; end
         CMD_POINT: begin
            mul_a = m_ff[idx_ff * 4'd3 + {2'b0, k_ff}];
            mul_b = (k_ff == 2'd0) ? a_ff : (k_ff == 2'd1) ? b_ff : c_ff;
         end
         default: begin
            mul_a = t_ff[ii * 4'd3 + {2'b0, k_ff}];
            mul_b = m_ff[{2'b0, k_ff} * 4'd3 + jj];
         end
      endcase

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_pop_request ? CMD_POP : cmd_type'(req_type);
               a_in = req_operand_a; b_in = req_operand_b; c_in = req_operand_c;
               row_in = req_element_row; col_in = req_element_col;
               px_in = '0; py_in = '0; pw_in = '0; st_in = ST_OK;
               idx_in = '0; k_in = '0; acc_in = '0; step_in = '0;
               for (int i = 0; i < 9; i++)
                  t_in[i] = (i == 0 || i == 4 || i == 8) ? Q_ONE : 32'sd0;
               state_in = S_DONE;
               if (req_pop_request) state_in = S_POPRD;
               else case (req_type)
                  CMD_IDENTITY: for (int i = 0; i < 9; i++)
                     m_in[i] = (i == 0 || i == 4 || i == 8) ? Q_ONE : 32'sd0;
                  CMD_ZERO: for (int i = 0; i < 9; i++) m_in[i] = '0;
                  CMD_WRITE:
                     if (req_element_row != 2'd3 && req_element_col != 2'd3)
                        m_in[{2'b0, req_element_row} * 4'd3 + {2'b0, req_element_col}]
                           = req_operand_a;
                  CMD_SCALE: begin
                     t_in[0] = req_operand_a; t_in[4] = req_operand_b;
                     state_in = S_MAC;
                  end
                  CMD_TRANS: begin
                     t_in[2] = req_operand_a; t_in[5] = req_operand_b;
                     state_in = S_MAC;
                  end
                  CMD_ROTATE: begin
                     z_in = 48'(req_operand_a) <<< 14;
                     state_in = S_REDUCE;
                  end
                  CMD_SCALAR, CMD_POINT: state_in = S_MAC;
                  CMD_PUSH: begin
                     if (cnt_ff >= CW'(STACK_DEPTH)) st_in = ST_OVERFLOW;
                     else state_in = S_PUSH;
                  end
                  CMD_POP: state_in = S_POPRD;
                  default: ;
               endcase
               if (state_in == S_POPRD && cnt_ff == '0) begin
                  st_in = ST_UNDERFLOW;
                  state_in = S_DONE;
               end
            end
         end
         S_REDUCE: begin
            // |z| <= 2^45; remove 2pi multiples by repeated subtraction of
            // shifted 2pi, restoring-style, one bit per cycle
            zr = z_ff;
            if (step_ff == 5'd0) begin
               neg_in = z_ff < 0;
               z_in = (z_ff < 0) ? -z_ff : z_ff;
               step_in = 5'd14;
            end else begin
               zr = z_ff - (48'(Q30_TWO_PI) <<< (step_ff - 5'd1));
               if (zr >= 0) z_in = zr;
               step_in = step_ff - 5'd1;
               if (step_ff == 5'd1) state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            zr = neg_ff ? -z_ff : z_ff;
            if (zr < 0) zr = zr + 48'(Q30_TWO_PI);
            if (zr > 48'(Q30_PI)) zr = zr - 48'(Q30_TWO_PI);
            neg_in = 1'b0;
            if (zr > 48'(Q30_HALF_PI)) begin
               zr = zr - 48'(Q30_PI); neg_in = 1'b1;
            end else if (zr < -48'(Q30_HALF_PI)) begin
               zr = zr + 48'(Q30_PI); neg_in = 1'b1;
            end
            z_in = zr; x_in = Q30_GAIN; y_in = '0; step_in = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            xs = x_ff >>> step_ff;
            ys = y_ff >>> step_ff;
            if (z_ff >= 0) begin
               x_in = x_ff - ys; y_in = y_ff + xs;
               z_in = z_ff - 48'(atan_q30(step_ff));
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs;
               z_in = z_ff + 48'(atan_q30(step_ff));
            end
            step_in = step_ff + 5'd1;
            if (32'(step_ff) == CORDIC_STEPS - 1) state_in = S_CROUND;
         end
         S_CROUND: begin
            xs = neg_ff ? -x_ff : x_ff;
            ys = neg_ff ? -y_ff : y_ff;
            t_in[0] = sat32(64'((xs + 36'sd8192) >>> 14));
            t_in[4] = t_in[0];
            t_in[3] = sat32(64'((ys + 36'sd8192) >>> 14));
            t_in[1] = sat32(-64'((ys + 36'sd8192) >>> 14));
            state_in = S_MAC;
         end
         S_MAC: begin
            prod_in = 64'(mul_a) * 64'(mul_b);
            state_in = S_MACW;
         end
         S_MACW: begin
            state_in = S_MAC;
            case (cmd_ff)
               CMD_SCALAR: begin
                  m_in[idx_ff] = sat32(rnd);
                  idx_in = idx_ff + 4'd1;
                  if (idx_ff == 4'd8) state_in = S_DONE;
               end
               default: begin
                  acc_in = acc_ff + rnd;
                  k_in = k_ff + 2'd1;
                  if (k_ff == 2'd2) begin
                     k_in = '0; acc_in = '0;
                     idx_in = idx_ff + 4'd1;
                     if (cmd_ff == CMD_POINT) begin
                        case (idx_ff)
                           4'd0: px_in = sat32(acc_ff + rnd);
                           4'd1: py_in = sat32(acc_ff + rnd);
                           default: pw_in = sat32(acc_ff + rnd);
                        endcase
                        if (idx_ff == 4'd2) state_in = S_DONE;
                     end else begin
                        tmp_in[idx_ff] = sat32(acc_ff + rnd);
                        if (idx_ff == 4'd8) begin
                           for (int i = 0; i < 8; i++) m_in[i] = tmp_ff[i];
                           m_in[8] = sat32(acc_ff + rnd);
                           state_in = S_DONE;
                        end
                     end
                  end
               end
            endcase
         end
         S_PUSH: begin
            ram_we = 1'b1; ram_wa = base + AW'(idx_ff); ram_wd = m_ff[idx_ff];
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd8) begin
               cnt_in = cnt_ff + CW'(1);
               state_in = S_DONE;
            end
         end
         S_POPRD: begin
            ram_ra = AW'((cnt_ff - CW'(1)) * 9);
            idx_in = 4'd1;
            state_in = S_POPLD;
         end
         S_POPLD: begin
            ram_ra = AW'((cnt_ff - CW'(1)) * 9) + AW'(idx_ff);
            m_in[idx_ff - 4'd1] = ram_rd;
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd9) begin
               cnt_in = cnt_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_POPWT: state_in = S_POPLD;
         S_DONE: begin
            done_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = done_ff;
   assign rsp_point_x = px_ff;
   assign rsp_point_y = py_ff;
   assign rsp_point_w = pw_ff;
   assign rsp_status = st_ff;

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(STACK_DEPTH)) else $error("stack count out of range");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH && idx_ff == 4'd8) |=> cnt_ff == $past(cnt_ff) + CW'(1))
      else $error("push count");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
endmodule

### hdl/ate_ram.sv
module ate_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### test/testbench.sv
module testbench
   import ate_pkg::*;
;

   localparam int DEPTH = DEF_STACK_DEPTH;
   localparam int STEPS = DEF_CORDIC_STEPS;
   localparam int N_RANDOM = 1750;
   localparam longint CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [3:0]         kind;
      logic               pop;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic [1:0]         row;
      logic [1:0]         col;
      logic               typed;
      logic [1:0]         typed_status;
   } request_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] w;
      logic [1:0]         status;
   } response_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [3:0]         req_type;
   logic               req_pop_request;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic signed [31:0] req_operand_c;
   logic [1:0]         req_element_row;
   logic [1:0]         req_element_col;
   logic               rsp_valid;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic signed [31:0] rsp_point_w;
   logic [1:0]         rsp_status;

   affine_transform_engine_with_stack u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_pop_request(req_pop_request),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .req_operand_c(req_operand_c), .req_element_row(req_element_row),
      .req_element_col(req_element_col), .rsp_valid(rsp_valid),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_point_w(rsp_point_w), .rsp_status(rsp_status)
   );

   logic signed [31:0] matrix [9];
   logic signed [31:0] saved [DEPTH][9];
   int                 depth_used;
   response_type       pending_points [$];
   int                 errors;
   longint             cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic longint floor_sh(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic longint qmul(logic signed [31:0] x, logic signed [31:0] y);
      longint p;
      p = longint'(x) * longint'(y);
      return floor_sh(p + 64'sd32768, 16);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint arctan_step(int i);
      longint t [32];
      t = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
            128, 64, 32, 16, 8, 4, 2, 1, 1};
      return t[i];
   endfunction

   task automatic sine_cosine(input logic signed [31:0] ang,
                              output logic signed [31:0] s,
                              output logic signed [31:0] c);
      longint z, x, y, nx, two_pi, pi_q, half_pi;
      bit neg;
      two_pi = Q30_TWO_PI;
      pi_q = Q30_PI;
      half_pi = Q30_HALF_PI;
      z = longint'(ang) * 16384;
      x = Q30_GAIN;
      y = 0;
      neg = 0;
      z = z % two_pi;
      if (z < 0) z += two_pi;
      if (z > pi_q) z -= two_pi;
      if (z > half_pi) begin
         z -= pi_q;
         neg = 1;
      end else if (z < -half_pi) begin
         z += pi_q;
         neg = 1;
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
         if (z >= 0) begin
            nx = x - floor_sh(y, i);
            y = y + floor_sh(x, i);
            z -= arctan_step(i);
         end else begin
            nx = x + floor_sh(y, i);
            y = y - floor_sh(x, i);
            z += arctan_step(i);
         end
         x = nx;
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      c = clamp32(floor_sh(x + 8192, 14));
      s = clamp32(floor_sh(y + 8192, 14));
   endtask

   task automatic premultiply(input logic signed [31:0] t [9]);
      logic signed [31:0] tmp [9];
      longint acc;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
               acc += qmul(t[i*3+k], matrix[k*3+j]);
            tmp[i*3+j] = clamp32(acc);
         end
      matrix = tmp;
   endtask

   function automatic void set_identity();
      foreach (matrix[i]) matrix[i] = 0;
      matrix[0] = Q_ONE;
      matrix[4] = Q_ONE;
      matrix[8] = Q_ONE;
   endfunction

   task automatic apply_command(input request_type r, output response_type o);
      logic signed [31:0] t [9];
      logic signed [31:0] s, c;
      logic [3:0] cmd;
      cmd = r.pop ? CMD_POP : r.kind;
      o = '{0, 0, 0, ST_OK};
      t = '{Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE};
      case (cmd)
         CMD_IDENTITY: set_identity();
         CMD_ZERO: foreach (matrix[i]) matrix[i] = 0;
         CMD_WRITE: if (r.row < 3 && r.col < 3) matrix[r.row*3+r.col] = r.a;
         CMD_SCALE: begin
            t[0] = r.a;
            t[4] = r.b;
            premultiply(t);
         end
         CMD_TRANS: begin
            t[2] = r.a;
            t[5] = r.b;
            premultiply(t);
         end
         CMD_ROTATE: begin
            sine_cosine(r.a, s, c);
            t[0] = c;
            t[1] = -s;
            t[3] = s;
            t[4] = c;
            premultiply(t);
         end
         CMD_SCALAR: foreach (matrix[i]) matrix[i] = clamp32(qmul(matrix[i], r.a));
         CMD_POINT: begin
            o.x = clamp32(qmul(matrix[0], r.a) + qmul(matrix[1], r.b)
                          + qmul(matrix[2], r.c));
            o.y = clamp32(qmul(matrix[3], r.a) + qmul(matrix[4], r.b)
                          + qmul(matrix[5], r.c));
            o.w = clamp32(qmul(matrix[6], r.a) + qmul(matrix[7], r.b)
                          + qmul(matrix[8], r.c));
         end
         CMD_PUSH: begin
            if (depth_used >= DEPTH) o.status = ST_OVERFLOW;
            else begin
               saved[depth_used] = matrix;
               depth_used++;
            end
         end
         CMD_POP: begin
            if (depth_used == 0) o.status = ST_UNDERFLOW;
            else begin
               depth_used--;
               matrix = saved[depth_used];
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      response_type e;
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            e = pending_points.pop_front();
            if (rsp_point_x !== e.x) begin
               $error("point_x expected %0d got %0d", e.x, rsp_point_x);
               errors++;
            end
            if (rsp_point_y !== e.y) begin
               $error("point_y expected %0d got %0d", e.y, rsp_point_y);
               errors++;
            end
            if (rsp_point_w !== e.w) begin
               $error("point_w expected %0d got %0d", e.w, rsp_point_w);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status expected %0d got %0d", e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   task automatic send(input request_type r, input bit may_idle);
      response_type o;
      while (may_idle && $urandom_range(99) < 38) @(posedge clock);
      start <= 1'b1;
      req_type <= r.kind;
      req_pop_request <= r.pop;
      req_operand_a <= r.a;
      req_operand_b <= r.b;
      req_operand_c <= r.c;
      req_element_row <= r.row;
      req_element_col <= r.col;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      apply_command(r, o);
      if (r.typed && o.status !== r.typed_status) begin
         $error("status table expected %0d model %0d", r.typed_status, o.status);
         errors++;
      end
      pending_points.push_back(o);
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(196608)) - 32'sd98304;
         3: return $signed($urandom_range(600000)) - 32'sd300000;
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type rand_request();
      request_type r;
      int pick;
      pick = $urandom_range(99);
      r.pop = (pick < 12);
      if (pick < 12) r.kind = 4'($urandom);
      else if (pick < 22) r.kind = CMD_PUSH;
      else if (pick < 24) r.kind = 4'($urandom_range(10, 15));
      else r.kind = 4'($urandom_range(CMD_IDENTITY, CMD_POINT));
      r.a = rand_operand();
      r.b = rand_operand();
      r.c = rand_operand();
      if (r.kind == CMD_SCALE && $urandom_range(1)) begin
         r.a = $signed($urandom_range(131072)) - 32'sd65536;
         r.b = $signed($urandom_range(131072)) - 32'sd65536;
      end
      r.row = 2'($urandom);
      r.col = 2'($urandom);
      r.typed = 0;
      r.typed_status = ST_OK;
      return r;
   endfunction

   request_type directed [$];

   function automatic request_type mk(logic [3:0] k, logic p, logic signed [31:0] a,
                                      logic signed [31:0] b, logic signed [31:0] c,
                                      logic [1:0] row, logic [1:0] col, logic t,
                                      logic [1:0] st);
      request_type r;
      r = '{k, p, a, b, c, row, col, t, st};
      return r;
   endfunction

   initial begin
      request_type r;
      bit calm;
      errors = 0;
      cycles = 0;
      depth_used = 0;
      set_identity();
      reset = 1'b1;
      start = 1'b0;
      req_type = CMD_IDENTITY;
      req_pop_request = 1'b0;
      req_operand_a = 0;
      req_operand_b = 0;
      req_operand_c = 0;
      req_element_row = 0;
      req_element_col = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(mk(CMD_POP, 0, 0, 0, 0, 0, 0, 1, ST_UNDERFLOW));
      directed.push_back(mk(CMD_POINT, 0, Q_ONE, 2*Q_ONE, Q_ONE, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_POINT, 0, 32'sh7fffffff, 32'sh80000000,
                            32'sh7fffffff, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_WRITE, 0, 32'sh7fffffff, 0, 0, 3, 1, 1, ST_OK));
      directed.push_back(mk(CMD_WRITE, 0, 32'sh80000000, 0, 0, 1, 2, 1, ST_OK));
      directed.push_back(mk(CMD_SCALE, 0, 32'sh7fffffff, 32'sh80000000, 0, 0, 0,
                            1, ST_OK));
      directed.push_back(mk(CMD_POINT, 0, 32'sh7fffffff, 32'sh7fffffff, Q_ONE, 0,
                            0, 1, ST_OK));
      directed.push_back(mk(CMD_IDENTITY, 0, 0, 0, 0, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_TRANS, 0, 3*Q_ONE, -5*Q_ONE, 0, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_ROTATE, 0, 32'sh7fffffff, 0, 0, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_ROTATE, 0, 32'sh80000000, 0, 0, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_ROTATE, 0, 32'sd102944, 0, 0, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_SCALAR, 0, -32'sd65536, 0, 0, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_POINT, 0, Q_ONE, Q_ONE, Q_ONE, 0, 0, 1, ST_OK));
      directed.push_back(mk(4'd15, 0, 0, 0, 0, 0, 0, 1, ST_OK));
      directed.push_back(mk(4'd10, 0, 0, 0, 0, 0, 0, 1, ST_OK));
      for (int i = 0; i < DEPTH; i++)
         directed.push_back(mk(CMD_PUSH, 0, 0, 0, 0, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_PUSH, 0, 0, 0, 0, 0, 0, 1, ST_OVERFLOW));
      directed.push_back(mk(CMD_ZERO, 1, 0, 0, 0, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_ZERO, 0, 0, 0, 0, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_POP, 0, 0, 0, 0, 0, 0, 1, ST_OK));
      directed.push_back(mk(CMD_POINT, 0, Q_ONE, Q_ONE, Q_ONE, 0, 0, 1, ST_OK));
      foreach (directed[i]) send(directed[i], 1);

      while (pending_points.size() != 0) @(posedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 600 && n < 800);
         r = rand_request();
         if (n % 150 == 149 && $urandom_range(1)) begin
            r.kind = CMD_IDENTITY;
            r.pop = 0;
         end
         send(r, !calm);
      end

      while (pending_points.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   final begin
   end
endmodule
